/* design/shs_pkg.sv */
// Package for the stepper homing sequencer: codes, payload and state types.
`default_nettype none
package shs_pkg;

	localparam int TIME_BITS_DEF = 32;
	localparam int DIST_W        = 16;
	localparam int MS_W          = 16;
	localparam int NOW_W         = 32;
	localparam int CFG_IDX_W     = 2;

	localparam logic [DIST_W-1:0] CLEAR_DIST_RST = 16'd200;
	localparam logic [DIST_W-1:0] SWEEP_DIST_RST = 16'd5000;
	localparam logic [MS_W-1:0]   STABLE_MS_RST  = 16'd50;

	localparam logic [CFG_IDX_W-1:0] REG_CLEAR_DISTANCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SWEEP_DISTANCE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STABLE_MS      = 2'd2;

	typedef enum logic [1:0] {
		OP_TICK      = 2'd0,
		OP_SET_MODE  = 2'd1,
		OP_SET_TEACH = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		MODE_IDLE        = 3'd0,
		MODE_TEACH_START = 3'd1,
		MODE_CLEARING    = 3'd2,
		MODE_SWEEPING    = 3'd3,
		MODE_TEACH_DONE  = 3'd4,
		MODE_MOVE        = 3'd5,
		MODE_LASER       = 3'd6,
		MODE_MANUAL      = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		CMD_NONE      = 2'd0,
		CMD_MOVE      = 2'd1,
		CMD_STOP_ZERO = 2'd2
	} cmd_t;

	typedef struct packed {
		opcode_t          opcode;
		mode_t            new_mode;
		logic             teach_value;
		logic             sensor_high;
		logic             move_complete;
		logic             laser_done;
		logic [NOW_W-1:0] now_ms;
	} shs_in_t;

	typedef struct packed {
		cmd_t              motor_command;
		logic [DIST_W-1:0] move_distance;
		mode_t             mode;
		logic              teach_done;
	} shs_out_t;

	typedef struct packed {
		logic [DIST_W-1:0] clear_distance;
		logic [DIST_W-1:0] sweep_distance;
		logic [MS_W-1:0]   stable_ms;
	} shs_cfg_t;

	typedef struct packed {
		mode_t mode;
		logic  teach_mark;
		logic  stable_valid;
		logic  clear_started;
	} shs_ctl_t;

endpackage
`default_nettype wire

/* design/shs_if.sv */
// Valid/ready channel interfaces for the sequencer's input and result words.
`default_nettype none
interface shs_in_if import shs_pkg::*; ();
	logic    valid;
	logic    ready;
	shs_in_t word;

	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

interface shs_out_if import shs_pkg::*; ();
	logic     valid;
	logic     ready;
	shs_out_t word;

	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface
`default_nettype wire

/* design/stepper_homing_sequencer.sv */
// Stepper homing sequencer: top level with input stage, state and result register.
//
// Usage: each word on in_ch is an update tick (sensor, done flags, ms time) or a
// direct write of the mode or the teach mark. Every word yields exactly one
// result word on out_ch: motor command, move distance, mode and teach mark.
// Both channels are valid/ready; a word moves when valid and ready are high.
// Each accepted word passes through the input register, then the result register;
// out_ch.valid rises when the word enters the result register. Throughput is one
// word per clock while out_ch is not stalled; the mode/timer state is updated as
// each word enters the result register, before the next word leaves the input
// register. When the receiver stalls, the result register holds and the input
// register takes one more word; in_ch.ready then drops until out_ch drains.
// Configuration (clear_distance, sweep_distance, stable_ms) is written through
// cfg_we/cfg_index/cfg_data; the user must write it only while no word is in
// flight, which the block does not enforce. Unknown indexes are ignored. Reset
// (arst_n low) empties both stages, sets mode idle, clears the teach mark and
// the stable timer, and loads the register defaults.
`default_nettype none
module stepper_homing_sequencer import shs_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DIST_W-1:0]    cfg_data,
	shs_in_if.sink                    in_ch,
	shs_out_if.source                 out_ch
);

	shs_cfg_t             cfg_q;
	shs_ctl_t             ctl_q;
	shs_ctl_t             ctl_nxt;
	logic [TIME_BITS-1:0] start_q;
	logic [TIME_BITS-1:0] start_nxt;
	shs_in_t              item_s1;
	logic                 valid_s1;
	shs_out_t             result;
	shs_out_t             out_q;
	logic                 out_valid_q;
	logic                 advance;

	// advance the input stage when the result register is free or draining
	assign advance      = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || advance;
	assign out_ch.valid = out_valid_q;
	assign out_ch.word  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clear_distance <= CLEAR_DIST_RST;
			cfg_q.sweep_distance <= SWEEP_DIST_RST;
			cfg_q.stable_ms      <= STABLE_MS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CLEAR_DISTANCE: cfg_q.clear_distance <= cfg_data;
				REG_SWEEP_DISTANCE: cfg_q.sweep_distance <= cfg_data;
				REG_STABLE_MS:      cfg_q.stable_ms      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) item_s1 <= in_ch.word;
	end

	shs_step #(
		.TIME_BITS(TIME_BITS)
	) u_step (
		.item        (item_s1),
		.cfg         (cfg_q),
		.cur         (ctl_q),
		.stable_start(start_q),
		.nxt         (ctl_nxt),
		.start_nxt   (start_nxt),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.mode          <= MODE_IDLE;
			ctl_q.teach_mark    <= 1'b0;
			ctl_q.stable_valid  <= 1'b0;
			ctl_q.clear_started <= 1'b0;
			start_q             <= '0;
			out_valid_q         <= 1'b0;
		end else begin
			if (advance) begin
				ctl_q   <= ctl_nxt;
				start_q <= start_nxt;
			end
			if (advance) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) out_q <= result;
	end

`ifndef SYNTHESIS
	a_stop_goes_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.motor_command == CMD_STOP_ZERO |-> out_q.mode == MODE_TEACH_DONE)
		else $error("stop-and-zero word without teach-done mode");

	a_move_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.motor_command == CMD_MOVE
		|-> out_q.mode == MODE_CLEARING || out_q.mode == MODE_SWEEPING)
		else $error("move word outside clearing or sweeping");

	a_dist_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.motor_command != CMD_MOVE |-> out_q.move_distance == '0)
		else $error("nonzero distance without move command");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !out_ch.ready |-> !in_ch.ready)
		else $error("input taken while both stages are full");

	a_clear_mode: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ctl_q.clear_started) |-> ctl_q.mode == MODE_CLEARING)
		else $error("clear started without entering clearing");
`endif

endmodule
`default_nettype wire

/* design/shs_step.sv */
// Next-state and result logic for one sequencer word.
`default_nettype none
module shs_step import shs_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  shs_in_t              item,
	input  shs_cfg_t             cfg,
	input  shs_ctl_t             cur,
	input  logic [TIME_BITS-1:0] stable_start,
	output shs_ctl_t             nxt,
	output logic [TIME_BITS-1:0] start_nxt,
	output shs_out_t             result
);

	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] elapsed;
	logic                 timed_out;

	assign now_t     = TIME_BITS'(item.now_ms);
	assign elapsed   = now_t - stable_start;
	assign timed_out = elapsed > TIME_BITS'(cfg.stable_ms);

	always_comb begin
		nxt                  = cur;
		start_nxt            = stable_start;
		result.motor_command = CMD_NONE;
		result.move_distance = '0;
		case (item.opcode)
			OP_SET_MODE: begin
				nxt.mode = item.new_mode;
			end
			OP_SET_TEACH: begin
				nxt.teach_mark = item.teach_value;
			end
			OP_TICK: begin
				case (cur.mode)
					MODE_TEACH_START: begin
						if (item.sensor_high) begin
							// blocked restart: a clear move is still outstanding
							if (!cur.clear_started) begin
								result.motor_command = CMD_MOVE;
								result.move_distance = cfg.clear_distance;
								nxt.clear_started    = 1'b1;
								nxt.mode             = MODE_CLEARING;
							end
						end else begin
							result.motor_command = CMD_MOVE;
							result.move_distance = cfg.sweep_distance;
							nxt.mode             = MODE_SWEEPING;
						end
					end
					MODE_CLEARING: begin
						if (item.move_complete) begin
							nxt.mode          = MODE_TEACH_START;
							nxt.clear_started = 1'b0;
						end
					end
					MODE_SWEEPING: begin
						if (item.sensor_high) begin
							if (!cur.stable_valid) begin
								start_nxt        = now_t;
								nxt.stable_valid = 1'b1;
							end else if (timed_out) begin
								result.motor_command = CMD_STOP_ZERO;
								nxt.stable_valid     = 1'b0;
								nxt.mode             = MODE_TEACH_DONE;
							end
						end else begin
							nxt.stable_valid = 1'b0;
						end
					end
					MODE_TEACH_DONE: begin
						nxt.teach_mark = 1'b1;
						nxt.mode       = MODE_IDLE;
					end
					MODE_MOVE: begin
						if (item.move_complete) nxt.mode = MODE_TEACH_DONE;
					end
					MODE_LASER: begin
						if (item.laser_done) nxt.mode = MODE_IDLE;
					end
					MODE_MANUAL: begin
						nxt.teach_mark = 1'b0;
						nxt.mode       = MODE_IDLE;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		result.mode       = nxt.mode;
		result.teach_done = nxt.teach_mark;
	end

endmodule
`default_nettype wire

/* sim/stepper_homing_sequencer_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the stepper homing sequencer: directed table, then random words.
module stepper_homing_sequencer_test;
	import shs_pkg::*;

	localparam logic [1:0]           OP_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int PHASES = 5;
	localparam int WORDS_PER_PHASE = 315;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIST_W-1:0]    cfg_data;

	shs_in_if  in_ch ();
	shs_out_if out_ch ();

	stepper_homing_sequencer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	// Sequencer copy kept by the testbench
	mode_t             seq_mode;
	logic              seq_teach;
	logic [NOW_W-1:0]  timer_start;
	logic              timer_valid;
	logic              clearing_open;
	logic [DIST_W-1:0] cfg_clear;
	logic [DIST_W-1:0] cfg_sweep;
	logic [MS_W-1:0]   cfg_stable;

	shs_out_t          expected_words[$];
	int                mismatches;
	bit                in_idle_on;
	bit                out_idle_on;
	int                stall_left;
	logic              sens_level;
	logic [NOW_W-1:0]  now_clock;

	typedef struct packed {
		logic [1:0]  op;
		logic [2:0]  nm;
		logic        tv, sens, mc, ld;
		logic [31:0] now;
		logic        typed;
		logic [1:0]  cmd;
		logic [15:0] distance;
		logic [2:0]  md;
		logic        td;
	} dir_row_t;

	// op, new mode, teach, sensor, moved, laser, now | typed?, cmd, distance, mode, teach
	dir_row_t dir_rows [0:25] = '{
		'{OP_TICK, MODE_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0,
			1'b1, CMD_NONE, 16'd0, MODE_IDLE, 1'b0},
		'{OP_UNUSED, MODE_MANUAL, 1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF,
			1'b1, CMD_NONE, 16'd0, MODE_IDLE, 1'b0},
		'{OP_SET_TEACH, MODE_IDLE, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0,
			1'b1, CMD_NONE, 16'd0, MODE_IDLE, 1'b1},
		'{OP_SET_MODE, MODE_MANUAL, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0,
			1'b1, CMD_NONE, 16'd0, MODE_MANUAL, 1'b1},
		'{OP_TICK, MODE_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0,
			1'b1, CMD_NONE, 16'd0, MODE_IDLE, 1'b0},
		'{OP_SET_MODE, MODE_TEACH_START, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0,
			1'b1, CMD_NONE, 16'd0, MODE_TEACH_START, 1'b0},
		'{OP_TICK, MODE_IDLE, 1'b0, 1'b1, 1'b0, 1'b0, 32'd5,
			1'b1, CMD_MOVE, CLEAR_DIST_RST, MODE_CLEARING, 1'b0},
		'{OP_TICK, MODE_IDLE, 1'b0, 1'b1, 1'b0, 1'b0, 32'd6,
			1'b0, CMD_NONE, 16'd0, MODE_IDLE, 1'b0},
		// rewrite the mode while the clearing move is still open
		'{OP_SET_MODE, MODE_TEACH_START, 1'b0, 1'b0, 1'b0, 1'b0, 32'd7,
			1'b0, CMD_NONE, 16'd0, MODE_IDLE, 1'b0},
		'{OP_TICK, MODE_IDLE, 1'b0, 1'b1, 1'b0, 1'b0, 32'd8,
			1'b1, CMD_NONE, 16'd0, MODE_TEACH_START, 1'b0},
		'{OP_SET_MODE, MODE_CLEARING, 1'b0, 1'b0, 1'b0, 1'b0, 32'd9,
			1'b0, CMD_NONE, 16'd0, MODE_IDLE, 1'b0},
		'{OP_TICK, MODE_IDLE, 1'b0, 1'b1, 1'b1, 1'b0, 32'd10,
			1'b0, CMD_NONE, 16'd0, MODE_IDLE, 1'b0},
		'{OP_TICK, MODE_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, 32'd11,
			1'b1, CMD_MOVE, SWEEP_DIST_RST, MODE_SWEEPING, 1'b0},
		// stable window across the wrap of the ms counter
		'{OP_TICK, MODE_IDLE, 1'b0, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFF0,
			1'b0, CMD_NONE, 16'd0, MODE_IDLE, 1'b0},
		'{OP_TICK, MODE_IDLE, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0000_0022,
			1'b0, CMD_NONE, 16'd0, MODE_IDLE, 1'b0},
		'{OP_TICK, MODE_IDLE, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0000_0023,
			1'b0, CMD_NONE, 16'd0, MODE_IDLE, 1'b0},
		'{OP_TICK, MODE_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, 32'd40,
			1'b1, CMD_NONE, 16'd0, MODE_IDLE, 1'b1},
		'{OP_SET_MODE, MODE_SWEEPING, 1'b0, 1'b0, 1'b0, 1'b0, 32'd50,
			1'b0, CMD_NONE, 16'd0, MODE_IDLE, 1'b0},
		'{OP_TICK, MODE_IDLE, 1'b0, 1'b1, 1'b0, 1'b0, 32'd100,
			1'b0, CMD_NONE, 16'd0, MODE_IDLE, 1'b0},
		'{OP_TICK, MODE_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, 32'd200,
			1'b0, CMD_NONE, 16'd0, MODE_IDLE, 1'b0},
		'{OP_TICK, MODE_IDLE, 1'b0, 1'b1, 1'b0, 1'b0, 32'd1000,
			1'b0, CMD_NONE, 16'd0, MODE_IDLE, 1'b0},
		'{OP_SET_MODE, MODE_MOVE, 1'b0, 1'b0, 1'b0, 1'b0, 32'd1001,
			1'b0, CMD_NONE, 16'd0, MODE_IDLE, 1'b0},
		'{OP_TICK, MODE_IDLE, 1'b0, 1'b0, 1'b1, 1'b0, 32'd1002,
			1'b0, CMD_NONE, 16'd0, MODE_IDLE, 1'b0},
		'{OP_SET_MODE, MODE_LASER, 1'b0, 1'b0, 1'b0, 1'b0, 32'd1003,
			1'b0, CMD_NONE, 16'd0, MODE_IDLE, 1'b0},
		'{OP_TICK, MODE_IDLE, 1'b0, 1'b0, 1'b0, 1'b1, 32'd1004,
			1'b0, CMD_NONE, 16'd0, MODE_IDLE, 1'b0},
		'{OP_SET_TEACH, MODE_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, 32'd1005,
			1'b1, CMD_NONE, 16'd0, MODE_IDLE, 1'b0}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Advance the sequencer copy by one word and return the result it yields
	function automatic shs_out_t step_sequencer(input shs_in_t w);
		shs_out_t         res;
		logic [NOW_W-1:0] elapsed;
		res.motor_command = CMD_NONE;
		res.move_distance = '0;
		elapsed = w.now_ms - timer_start;
		case (w.opcode)
			OP_SET_MODE: seq_mode = w.new_mode;
			OP_SET_TEACH: seq_teach = w.teach_value;
			OP_TICK: begin
				case (seq_mode)
					MODE_TEACH_START: begin
						if (!w.sensor_high) begin
							res.motor_command = CMD_MOVE;
							res.move_distance = cfg_sweep;
							seq_mode = MODE_SWEEPING;
						end else if (!clearing_open) begin
							res.motor_command = CMD_MOVE;
							res.move_distance = cfg_clear;
							clearing_open = 1'b1;
							seq_mode = MODE_CLEARING;
						end
					end
					MODE_CLEARING: begin
						if (w.move_complete) begin
							seq_mode = MODE_TEACH_START;
							clearing_open = 1'b0;
						end
					end
					MODE_SWEEPING: begin
						if (!w.sensor_high) begin
							timer_valid = 1'b0;
						end else if (!timer_valid) begin
							timer_start = w.now_ms;
							timer_valid = 1'b1;
						end else if (elapsed > {{(NOW_W-MS_W){1'b0}}, cfg_stable}) begin
							res.motor_command = CMD_STOP_ZERO;
							timer_valid = 1'b0;
							seq_mode = MODE_TEACH_DONE;
						end
					end
					MODE_TEACH_DONE: begin
						seq_teach = 1'b1;
						seq_mode = MODE_IDLE;
					end
					MODE_MOVE: begin
						if (w.move_complete) seq_mode = MODE_TEACH_DONE;
					end
					MODE_LASER: begin
						if (w.laser_done) seq_mode = MODE_IDLE;
					end
					MODE_MANUAL: begin
						seq_teach = 1'b0;
						seq_mode = MODE_IDLE;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		res.mode = seq_mode;
		res.teach_done = seq_teach;
		return res;
	endfunction

	// Mostly well-formed homing runs: sticky sensor, slowly advancing ms clock
	function automatic shs_in_t next_random_word();
		shs_in_t w;
		int      pick;
		pick = $urandom_range(0, 99);
		w.opcode = OP_TICK;
		if (pick < 3) w.opcode = opcode_t'(OP_UNUSED);
		else if (pick < 13) w.opcode = OP_SET_MODE;
		else if (pick < 17) w.opcode = OP_SET_TEACH;
		w.new_mode = ($urandom_range(0, 1) == 0) ? MODE_TEACH_START
			: mode_t'($urandom_range(0, 7));
		w.teach_value = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 5) == 0) sens_level = ~sens_level;
		w.sensor_high = sens_level;
		w.move_complete = ($urandom_range(0, 3) == 0);
		w.laser_done = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 49) == 0) now_clock = $urandom;
		else now_clock = now_clock + $urandom_range(0, 25);
		w.now_ms = now_clock;
		return w;
	endfunction

	// Called at a falling edge; returns at the falling edge after the word moved
	task automatic send_word(input shs_in_t w, input bit typed, input shs_out_t fixed);
		shs_out_t pred;
		if (in_idle_on && $urandom_range(0, 5) == 0) begin
			in_ch.valid = 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.word = w;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		pred = step_sequencer(w);
		expected_words.push_back(typed ? fixed : pred);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIST_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		case (idx)
			REG_CLEAR_DISTANCE: cfg_clear = data;
			REG_SWEEP_DISTANCE: cfg_sweep = data;
			REG_STABLE_MS: cfg_stable = data;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_config(input logic [DIST_W-1:0] clear_d, input logic [DIST_W-1:0] sweep_d,
			input logic [MS_W-1:0] stable_t);
		write_reg(REG_CLEAR_DISTANCE, clear_d);
		write_reg(REG_SWEEP_DISTANCE, sweep_d);
		write_reg(REG_STABLE_MS, stable_t);
		cfg_we = 1'b0;
	endtask

	task automatic wait_drained();
		while (expected_words.size() != 0) @(posedge clk);
		repeat (3) @(negedge clk);
	endtask

	initial begin
		out_ch.ready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left != 0) begin
				out_ch.ready = 1'b0;
				stall_left--;
			end else if (out_idle_on && $urandom_range(0, 7) == 0) begin
				out_ch.ready = 1'b0;
				stall_left = $urandom_range(0, 14);
			end else begin
				out_ch.ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		shs_out_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_words.size() == 0) begin
				$error("result word with nothing expected: %p", out_ch.word);
				mismatches++;
			end else begin
				want = expected_words.pop_front();
				if (out_ch.word.motor_command !== want.motor_command) begin
					$error("motor_command: expected %0d, got %0d",
						want.motor_command, out_ch.word.motor_command);
					mismatches++;
				end
				if (out_ch.word.move_distance !== want.move_distance) begin
					$error("move_distance: expected %0d, got %0d",
						want.move_distance, out_ch.word.move_distance);
					mismatches++;
				end
				if (out_ch.word.mode !== want.mode) begin
					$error("mode: expected %0d, got %0d", want.mode, out_ch.word.mode);
					mismatches++;
				end
				if (out_ch.word.teach_done !== want.teach_done) begin
					$error("teach_done: expected %0d, got %0d",
						want.teach_done, out_ch.word.teach_done);
					mismatches++;
				end
			end
		end
	end

	initial begin
		shs_in_t  w;
		shs_out_t fixed;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_CLEAR_DISTANCE;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.word = '0;
		mismatches = 0;
		in_idle_on = 1'b1;
		out_idle_on = 1'b1;
		sens_level = 1'b0;
		now_clock = '0;
		seq_mode = MODE_IDLE;
		seq_teach = 1'b0;
		timer_start = '0;
		timer_valid = 1'b0;
		clearing_open = 1'b0;
		cfg_clear = CLEAR_DIST_RST;
		cfg_sweep = SWEEP_DIST_RST;
		cfg_stable = STABLE_MS_RST;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			w.opcode = opcode_t'(dir_rows[i].op);
			w.new_mode = mode_t'(dir_rows[i].nm);
			w.teach_value = dir_rows[i].tv;
			w.sensor_high = dir_rows[i].sens;
			w.move_complete = dir_rows[i].mc;
			w.laser_done = dir_rows[i].ld;
			w.now_ms = dir_rows[i].now;
			fixed.motor_command = cmd_t'(dir_rows[i].cmd);
			fixed.move_distance = dir_rows[i].distance;
			fixed.mode = mode_t'(dir_rows[i].md);
			fixed.teach_done = dir_rows[i].td;
			send_word(w, dir_rows[i].typed, fixed);
		end
		in_ch.valid = 1'b0;

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			case (ph)
				1: set_config(16'd0, 16'hFFFF, 16'd0);
				2: begin
					write_reg(REG_UNUSED, DIST_W'($urandom));
					set_config(16'hFFFF, 16'd0, 16'hFFFF);
				end
				3: set_config(DIST_W'($urandom), DIST_W'($urandom),
					MS_W'($urandom_range(0, 100)));
				4: set_config(DIST_W'($urandom), DIST_W'($urandom),
					MS_W'($urandom_range(1, 300)));
				default: ;
			endcase
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				// no idling at all through the last phase
				if (n % 100 == 0) begin
					in_idle_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
					out_idle_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
				end
				send_word(next_random_word(), 1'b0, '0);
			end
			in_ch.valid = 1'b0;
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

/* stepper_homing_sequencer.f */
design/shs_pkg.sv
design/shs_if.sv
design/shs_step.sv
design/stepper_homing_sequencer.sv
sim/stepper_homing_sequencer_test.sv
